/* sv/prp_pkg.sv */
// ----------------------------------------------------------------------------
// prp_pkg - shared types and constants for the point rotate/perspective block
// Configuration layout, register indexes, fixed offsets and pipeline depths.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam logic signed [15:0] CENTRE_X     = 16'sd950;
  localparam logic signed [15:0] CENTRE_Y     = 16'sd900;
  localparam logic signed [15:0] CENTRE_Z     = 16'sd150;
  // (1500 << 15) / 0x1fff, truncated
  localparam logic signed [15:0] DEPTH_OFFSET = 16'sd6000;
  localparam logic [13:0]        PERSP_DIV    = 14'h1fff;
  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;

  localparam int DIV_STEPS  = 30;  // quotient bits of |x*scale| / |z|
  localparam int SQRT_STEPS = 16;  // root bits of a 32-bit sum of squares

  typedef enum logic [2:0] {
    REG_SIN_X    = 3'd0,
    REG_COS_X    = 3'd1,
    REG_SIN_Y    = 3'd2,
    REG_COS_Y    = 3'd3,
    REG_SIN_Z    = 3'd4,
    REG_COS_Z    = 3'd5,
    REG_CENTRE_X = 3'd6,
    REG_CENTRE_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] sin_x;
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_y;
    logic signed [15:0] cos_y;
    logic signed [15:0] sin_z;
    logic signed [15:0] cos_z;
    logic [11:0]        centre_x;
    logic [11:0]        centre_y;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } point_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [14:0]        distance;
    logic               depth_was_zero;
    logic               frame_end;
  } result_t;

  // Q1.14 product sum scaled down, truncated toward zero, wrapped to 16 bits
  function automatic logic signed [15:0] rot_q14(input logic signed [32:0] acc);
    logic signed [32:0] adj;
    adj = acc[32] ? (acc + 33'sd16383) : acc;
    return adj[29:14];
  endfunction

endpackage

/* sv/prp_rotate.sv */
// ----------------------------------------------------------------------------
// prp_rotate - centre offset and three-axis rotation pipeline
// Seven stages: offset, then multiply/accumulate pairs for Y, X and Z axes.
// ----------------------------------------------------------------------------
module prp_rotate
  import prp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  point_t in_pt,
  output logic   out_valid,
  output point_t out_pt
);

  logic [6:0] vld;

  logic signed [15:0] x1, y1, z1;
  logic signed [31:0] pa2, pb2, pc2, pd2;
  logic signed [15:0] y2;
  logic signed [15:0] x3, y3, z3;
  logic signed [31:0] pa4, pb4, pc4, pd4;
  logic signed [15:0] x4;
  logic signed [15:0] x5, y5, z5;
  logic signed [31:0] pa6, pb6, pc6, pd6;
  logic signed [15:0] z6;
  logic signed [15:0] x7, y7, z7;
  logic [6:0]         last;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last <= {last[5:0], in_pt.last};
      // offset from model centre
      x1 <= in_pt.x - CENTRE_X;
      y1 <= in_pt.y - CENTRE_Y;
      z1 <= in_pt.z - CENTRE_Z;
      // about Y
      pa2 <= x1 * cfg.cos_y;
      pb2 <= z1 * cfg.sin_y;
      pc2 <= x1 * cfg.sin_y;
      pd2 <= z1 * cfg.cos_y;
      y2  <= y1;
      x3  <= rot_q14(33'(pa2) - 33'(pb2));
      z3  <= rot_q14(33'(pc2) + 33'(pd2));
      y3  <= y2;
      // about X
      pa4 <= y3 * cfg.cos_x;
      pb4 <= z3 * cfg.sin_x;
      pc4 <= y3 * cfg.sin_x;
      pd4 <= z3 * cfg.cos_x;
      x4  <= x3;
      y5  <= rot_q14(33'(pa4) - 33'(pb4));
      z5  <= rot_q14(33'(pc4) + 33'(pd4));
      x5  <= x4;
      // about Z; depth pushed back
      pa6 <= x5 * cfg.cos_z;
      pb6 <= y5 * cfg.sin_z;
      pc6 <= x5 * cfg.sin_z;
      pd6 <= y5 * cfg.cos_z;
      z6  <= z5 + DEPTH_OFFSET;
      x7  <= rot_q14(33'(pa6) - 33'(pb6));
      y7  <= rot_q14(33'(pc6) + 33'(pd6));
      z7  <= z6;
    end
  end

  assign out_valid   = vld[6];
  assign out_pt.x    = x7;
  assign out_pt.y    = y7;
  assign out_pt.z    = z7;
  assign out_pt.last = last[6];

endmodule

/* sv/prp_solve.sv */
// ----------------------------------------------------------------------------
// prp_solve - distance and perspective divide pipeline
// Squares, scaled products, then a quotient bit a stage, a root bit in g_root.
// ----------------------------------------------------------------------------
module prp_solve
  import prp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  point_t  in_pt,
  output logic    out_valid,
  output result_t out_res
);

  localparam int N = DIV_STEPS;

  // scale = (min(cx,cy) << 15) / 0x1fff = 4*m + (4*m >= 0x1fff)
  logic [11:0] minc;
  logic [13:0] minc4;
  logic [14:0] scale;

  assign minc  = (cfg.centre_x >= cfg.centre_y) ? cfg.centre_y : cfg.centre_x;
  assign minc4 = {minc, 2'b00};
  assign scale = {1'b0, minc4} + {14'd0, (minc4 >= PERSP_DIV)};

  // stage A
  logic               va;
  logic [31:0]        sqx_a, sqy_a, sqz_a;
  logic signed [31:0] px_a, py_a;
  logic [15:0]        zmag_a;
  logic               zneg_a, zero_a, last_a;
  logic signed [15:0] x_a, y_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_a  <= 32'(in_pt.x * in_pt.x);
      sqy_a  <= 32'(in_pt.y * in_pt.y);
      sqz_a  <= 32'(in_pt.z * in_pt.z);
      px_a   <= in_pt.x * $signed({1'b0, scale});
      py_a   <= in_pt.y * $signed({1'b0, scale});
      zmag_a <= in_pt.z[15] ? (16'd0 - in_pt.z) : in_pt.z;
      zneg_a <= in_pt.z[15];
      zero_a <= (in_pt.z == 16'sd0);
      x_a    <= in_pt.x;
      y_a    <= in_pt.y;
      last_a <= in_pt.last;
    end
  end

  // chain of iterative stages; index 0 is loaded from stage A
  logic               vld   [N+1];
  logic [31:0]        sq_v  [N+1];
  logic [31:0]        sq_r  [N+1];
  logic [15:0]        remx  [N+1];
  logic [29:0]        nqx   [N+1];
  logic [15:0]        remy  [N+1];
  logic [29:0]        nqy   [N+1];
  logic [15:0]        dvs   [N+1];
  logic               negx  [N+1];
  logic               negy  [N+1];
  logic               zero  [N+1];
  logic               lst   [N+1];
  logic signed [15:0] xs    [N+1];
  logic signed [15:0] ys    [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v[0] <= sqx_a + sqy_a + sqz_a;
      sq_r[0] <= '0;
      remx[0] <= '0;
      nqx[0]  <= px_a[31] ? 30'(32'd0 - px_a) : px_a[29:0];
      remy[0] <= '0;
      nqy[0]  <= py_a[31] ? 30'(32'd0 - py_a) : py_a[29:0];
      dvs[0]  <= zmag_a;
      negx[0] <= px_a[31] ^ zneg_a;
      negy[0] <= py_a[31] ^ zneg_a;
      zero[0] <= zero_a;
      lst[0]  <= last_a;
      xs[0]   <= x_a;
      ys[0]   <= y_a;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [16:0] tx, ty;
    logic        gex, gey;
    logic [31:0] v_next, r_next;

    assign tx  = {remx[k], nqx[k][29]};
    assign ty  = {remy[k], nqy[k][29]};
    assign gex = (tx >= {1'b0, dvs[k]});
    assign gey = (ty >= {1'b0, dvs[k]});

    if (k < SQRT_STEPS) begin : g_root
      localparam logic [31:0] BITV = 32'h1 << (30 - 2 * k);
      logic [31:0] trial;
      assign trial = sq_r[k] + BITV;
      always_comb begin
        if (sq_v[k] >= trial) begin
          v_next = sq_v[k] - trial;
          r_next = (sq_r[k] >> 1) + BITV;
        end else begin
          v_next = sq_v[k];
          r_next = sq_r[k] >> 1;
        end
      end
    end else begin : g_hold
      assign v_next = sq_v[k];
      assign r_next = sq_r[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_v[k+1] <= v_next;
        sq_r[k+1] <= r_next;
        remx[k+1] <= gex ? 16'(tx - {1'b0, dvs[k]}) : tx[15:0];
        nqx[k+1]  <= {nqx[k][28:0], gex};
        remy[k+1] <= gey ? 16'(ty - {1'b0, dvs[k]}) : ty[15:0];
        nqy[k+1]  <= {nqy[k][28:0], gey};
        dvs[k+1]  <= dvs[k];
        negx[k+1] <= negx[k];
        negy[k+1] <= negy[k];
        zero[k+1] <= zero[k];
        lst[k+1]  <= lst[k];
        xs[k+1]   <= xs[k];
        ys[k+1]   <= ys[k];
      end
    end
  end

  // final stage: sign, centre, distance saturation; zero depth keeps raw x/y
  logic [15:0] qx, qy, sx, sy;

  assign qx = negx[N] ? (16'd0 - nqx[N][15:0]) : nqx[N][15:0];
  assign qy = negy[N] ? (16'd0 - nqy[N][15:0]) : nqy[N][15:0];
  assign sx = qx + {4'd0, cfg.centre_x};
  assign sy = qy + {4'd0, cfg.centre_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.screen_x       <= zero[N] ? xs[N] : $signed(sx);
      out_res.screen_y       <= zero[N] ? ys[N] : $signed(sy);
      out_res.distance       <= (|sq_r[N][31:15]) ? 15'h7fff : sq_r[N][14:0];
      out_res.depth_was_zero <= zero[N];
      out_res.frame_end      <= lst[N];
    end
  end

endmodule

/* sv/prp_out_buf.sv */
// ----------------------------------------------------------------------------
// prp_out_buf - output register with skid stage
// Holds the pipeline's result; a second slot lets the pipe run until it fills.
// ----------------------------------------------------------------------------
module prp_out_buf
  import prp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_res,
  output logic    en,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_res;
  logic    take;

  assign en   = !skid_valid;
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid && en) begin
      skid_res <= in_res;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid slot filled without a stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> !skid_valid && out_valid)
    else $error("skid slot not drained on ready");
`endif

endmodule

/* sv/point_rotate_perspective_top.sv */
// ----------------------------------------------------------------------------
// point_rotate_perspective_top - 3D point rotation and perspective projection
// Input beat: one model point; output beat: screen position and distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one point per beat (tlast marks the last point of a list),
//   m_* returns one result per point in the same order, tlast copied across.
//   cfg_we/cfg_index/cfg_data write the sine/cosine and screen centre
//   registers; write only while no points are in flight.
// Throughput: one point per clock unless m_tready stalls the pipe. A point
//   runs through the rotate stages, then the 30-stage bit-serial divider
//   chain (the square root runs alongside in its first 16 stages).
// Reset: rst (synchronous) empties the pipeline and loads identity rotation
//   and a screen centre of 64, 64.
// Stall: while m_tready is low the pipe keeps advancing until a result fills
//   the skid slot. s_tready then drops; the pipe holds until the slot drains.
// ----------------------------------------------------------------------------
module point_rotate_perspective_top
  import prp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // point_x, point_y, point_z
  input  logic        s_tlast,   // last_in_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // screen_x, screen_y, distance, depth_was_zero
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  logic    en;
  point_t  in_pt, rot_pt;
  logic    rot_valid, sol_valid;
  result_t sol_res, out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sin_x    <= '0;
      cfg.cos_x    <= ONE_Q14;
      cfg.sin_y    <= '0;
      cfg.cos_y    <= ONE_Q14;
      cfg.sin_z    <= '0;
      cfg.cos_z    <= ONE_Q14;
      cfg.centre_x <= 12'd64;
      cfg.centre_y <= 12'd64;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIN_X:    cfg.sin_x    <= cfg_data;
        REG_COS_X:    cfg.cos_x    <= cfg_data;
        REG_SIN_Y:    cfg.sin_y    <= cfg_data;
        REG_COS_Y:    cfg.cos_y    <= cfg_data;
        REG_SIN_Z:    cfg.sin_z    <= cfg_data;
        REG_COS_Z:    cfg.cos_z    <= cfg_data;
        REG_CENTRE_X: cfg.centre_x <= cfg_data[11:0];
        REG_CENTRE_Y: cfg.centre_y <= cfg_data[11:0];
        default:      ;
      endcase
    end
  end

  assign in_pt.x    = s_tdata[15:0];
  assign in_pt.y    = s_tdata[31:16];
  assign in_pt.z    = s_tdata[47:32];
  assign in_pt.last = s_tlast;
  assign s_tready   = en;

  prp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_pt     (in_pt),
    .out_valid (rot_valid),
    .out_pt    (rot_pt)
  );

  prp_solve u_solve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (rot_valid),
    .in_pt     (rot_pt),
    .out_valid (sol_valid),
    .out_res   (sol_res)
  );

  prp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sol_valid),
    .in_res    (sol_res),
    .en        (en),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {out_res.depth_was_zero, out_res.distance,
                    out_res.screen_y, out_res.screen_x};
  assign m_tlast = out_res.frame_end;

endmodule

/* tb/point_rotate_perspective_top_tb.sv */
// ----------------------------------------------------------------------------
// point_rotate_perspective_top_tb - self-checking bench for rotate/project
// Streams points through the block under several rotation and screen-centre
// settings and scores every output beat against an in-bench model of the
// arithmetic or a typed result. Directed rows come first, then random points;
// until the last two phases both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module point_rotate_perspective_top_tb;
  import prp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_POINTS   = 200;
  localparam int NUM_PHASES     = 6;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // point_x, point_y, point_z
  logic        s_tlast;   // last_in_frame
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // screen_x, screen_y, distance, depth_was_zero
  logic        m_tlast;   // frame_end
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  point_rotate_perspective_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    point_t  pt;
    bit      typed;
    result_t res;
  } dir_row_t;

  cfg_t      cfg_shadow;
  result_t   screen_q[$];
  dir_row_t  dir_rows[$];
  int        src_idle;
  int        sink_stall;
  int        hold_reqs;
  int        mismatches = 0;
  int        points_sent;
  int        results_seen = 0;
  int        zero_depths = 0;
  bit        failed = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [15:0] wrap16(longint v);
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rot_term(longint p, longint m, longint q,
                                                  longint n);
    longint acc;
    acc = p * m + q * n;
    return wrap16(acc / 16384);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic result_t project_point(point_t p, cfg_t c);
    logic signed [15:0] x, y, z, t;
    longint             sq, scale, minc;
    longint unsigned    root;
    result_t            r;
    x = wrap16(longint'(p.x) - 950);
    y = wrap16(longint'(p.y) - 900);
    z = wrap16(longint'(p.z) - 150);
    t = x;
    x = rot_term(x, c.cos_y, z, -longint'(c.sin_y));
    z = rot_term(t, c.sin_y, z, c.cos_y);
    t = y;
    y = rot_term(y, c.cos_x, z, -longint'(c.sin_x));
    z = rot_term(t, c.sin_x, z, c.cos_x);
    t = x;
    x = rot_term(x, c.cos_z, y, -longint'(c.sin_z));
    y = rot_term(t, c.sin_z, y, c.cos_z);
    z = wrap16(longint'(z) + 6000);
    sq   = longint'(x) * x + longint'(y) * y + longint'(z) * z;
    root = floor_root(sq);
    r.distance       = (root > 32767) ? 15'h7fff : root[14:0];
    r.depth_was_zero = (z == 0);
    r.frame_end      = p.last;
    if (z == 0) begin
      r.screen_x = x;
      r.screen_y = y;
    end else begin
      minc  = (c.centre_x >= c.centre_y) ? longint'(c.centre_y) : longint'(c.centre_x);
      scale = (minc << 15) / 8191;
      r.screen_x = wrap16(longint'(c.centre_x) + (longint'(x) * scale) / z);
      r.screen_y = wrap16(longint'(c.centre_y) + (longint'(y) * scale) / z);
    end
    return r;
  endfunction

  task automatic add_row(int x, int y, int z, bit last, bit typed,
                         int sx = 0, int sy = 0, int dist_exp = 0, bit zf = 0);
    dir_row_t row;
    row.pt.x = 16'(x); row.pt.y = 16'(y); row.pt.z = 16'(z); row.pt.last = last;
    row.typed = typed;
    row.res.screen_x = 16'(sx); row.res.screen_y = 16'(sy);
    row.res.distance = 15'(dist_exp);
    row.res.depth_was_zero = zf; row.res.frame_end = last;
    dir_rows.push_back(row);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_SIN_X:    cfg_shadow.sin_x    = v;
      REG_COS_X:    cfg_shadow.cos_x    = v;
      REG_SIN_Y:    cfg_shadow.sin_y    = v;
      REG_COS_Y:    cfg_shadow.cos_y    = v;
      REG_SIN_Z:    cfg_shadow.sin_z    = v;
      REG_COS_Z:    cfg_shadow.cos_z    = v;
      REG_CENTRE_X: cfg_shadow.centre_x = v[11:0];
      REG_CENTRE_Y: cfg_shadow.centre_y = v[11:0];
      default: ;
    endcase
  endtask

  // sender driven to idle here; waits for every expected beat, then settles if asked
  task automatic drain_pipe(bit settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (screen_q.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_point(point_t p, bit typed, result_t typed_res);
    bit ok;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.z, p.y, p.x};
    s_tlast  <= p.last;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    screen_q.push_back(typed ? typed_res : project_point(p, cfg_shadow));
    points_sent++;
  endtask

  function automatic logic [15:0] rand_trig();
    return 16'($urandom_range(32768)) - 16'd16384;
  endfunction

  task automatic configure(int ph);
    logic [15:0] s, c;
    case (ph)
      0: begin s = 16'd0;          c = 16'd16384;         end
      2: begin s = 16'd16384;      c = 16'd0;             end
      3: begin s = -16'sd16384;    c = -16'sd16384;       end
      4: begin s = 16'h8000;       c = 16'h7fff;          end
      default: begin s = rand_trig(); c = rand_trig();    end
    endcase
    write_reg(REG_SIN_X, s);
    write_reg(REG_COS_X, c);
    write_reg(REG_SIN_Y, (ph % 2) ? rand_trig() : s);
    write_reg(REG_COS_Y, (ph % 2) ? rand_trig() : c);
    write_reg(REG_SIN_Z, (ph % 2) ? rand_trig() : s);
    write_reg(REG_COS_Z, c);
    case (ph)
      0: begin write_reg(REG_CENTRE_X, 16'd0);    write_reg(REG_CENTRE_Y, 16'd0);    end
      2: begin write_reg(REG_CENTRE_X, 16'd4095); write_reg(REG_CENTRE_Y, 16'd4095); end
      3: begin write_reg(REG_CENTRE_X, 16'd4095); write_reg(REG_CENTRE_Y, 16'd0);    end
      default: begin
        write_reg(REG_CENTRE_X, 16'($urandom_range(4095)));
        write_reg(REG_CENTRE_Y, 16'($urandom_range(4095)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  function automatic point_t random_point(cfg_t c);
    point_t p;
    int     kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      {p.x, p.y, p.z} = 48'({$urandom, $urandom});
    end else if (kind < 35 && c.sin_y == 0 && c.sin_x == 0 && c.cos_x == 16384 &&
                 c.cos_y == 16384) begin
      // depth lands on zero under these angles
      p.x = 16'(950 + $urandom_range(6000) - 3000);
      p.y = 16'(900 + $urandom_range(6000) - 3000);
      p.z = -16'sd5850;
    end else begin
      p.x = 16'(950 + $urandom_range(8000) - 4000);
      p.y = 16'(900 + $urandom_range(8000) - 4000);
      p.z = 16'(150 + $urandom_range(8000) - 4000);
    end
    p.last = ($urandom_range(7) == 0);
    return p;
  endfunction

  // output side: random stall, plus a long hold-off on request
  initial begin
    int hold_cnt;
    int hold_seen;
    hold_cnt  = 0;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(negedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.screen_x       = m_tdata[15:0];
      got.screen_y       = m_tdata[31:16];
      got.distance       = m_tdata[46:32];
      got.depth_was_zero = m_tdata[47];
      got.frame_end      = m_tlast;
      results_seen++;
      if (screen_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h last %b", m_tdata, m_tlast);
      end else begin
        want = screen_q.pop_front();
        if (got.depth_was_zero) zero_depths++;
        if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
            got.distance !== want.distance || got.depth_was_zero !== want.depth_was_zero ||
            got.frame_end !== want.frame_end) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch beat %0d: exp x %0d y %0d d %0d z %b l %b, got x %0d y %0d d %0d z %b l %b",
                     results_seen, want.screen_x, want.screen_y, want.distance,
                     want.depth_was_zero, want.frame_end, got.screen_x, got.screen_y,
                     got.distance, got.depth_was_zero, got.frame_end);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beats for %0d cycles, %0d outputs pending",
                 quiet, screen_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    result_t none;
    point_t  p;
    none = '0;
    points_sent = 0;
    hold_reqs = 0;
    src_idle = 29; sink_stall = 82;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SIN_X;
    cfg_data  <= '0;
    cfg_shadow = '{sin_x: 0, cos_x: 16384, sin_y: 0, cos_y: 16384, sin_z: 0,
                   cos_z: 16384, centre_x: 64, centre_y: 64};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity rotation, centre 64: centre point, depth-zero points, extremes
    add_row(950, 900, 150, 0, 1, 64, 64, 6000, 0);
    add_row(950, 900, -5850, 1, 1, 0, 0, 0, 1);
    add_row(1950, 900, -5850, 0, 1, 1000, 0, 1000, 1);
    add_row(950, 1900, -5850, 1, 1, 0, 1000, 1000, 1);
    add_row(950, 900, -5851, 0, 0);
    add_row(950, 900, -5849, 0, 0);
    add_row(1950, 1900, -5849, 1, 0);
    add_row(-32768, -32768, -32768, 0, 0);
    add_row(32767, 32767, 32767, 1, 0);
    add_row(32767, -32768, 0, 0, 0);
    add_row(-32768, 32767, 32767, 0, 0);
    add_row(0, 0, 0, 1, 0);
    add_row(-1, -1, -1, 0, 0);
    add_row(21845, -21846, 10922, 1, 0);
    foreach (dir_rows[i]) send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].res);
    drain_pipe(1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        src_idle = 29; sink_stall = 82;
      end else if (ph < 4) begin
        src_idle = 82; sink_stall = 29;
      end else begin
        src_idle = 0; sink_stall = 0;
      end
      configure(ph);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (ph == 4 && n == 50) hold_reqs++;  // sender keeps pushing into a full pipe
        if (ph == 3 && n == 100) drain_pipe(1'b0);
        p = random_point(cfg_shadow);
        send_point(p, 1'b0, none);
      end
      drain_pipe(1'b1);
    end

    $display("%0d points in, %0d results out, %0d with zero depth, %0d mismatches",
             points_sent, results_seen, zero_depths, mismatches);
    $display("covered %0d register settings incl. unit, negative and out-of-range trig",
             NUM_PHASES + 1);
    if (!failed && screen_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
